// File: rtl/mra_pkg.sv
// Shared types and constants for the mouse report accumulator.
package mra_pkg;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_MOVE    = 2'd2,
        REQ_FLUSH   = 2'd3
    } req_type_t;

    // Status byte layout.
    localparam int unsigned BTN_BITS   = 4;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;
    localparam logic [7:0]  FLUSH_KEEP_MASK = 8'h0F;  // flush keeps the buttons only

    // One input transaction.
    typedef struct packed {
        req_type_t          req_type;
        logic [1:0]         button;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } req_item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] status_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
    } rpt_item_t;

endpackage

// File: rtl/mra_axis.sv
// Sign-magnitude update of one movement axis.
module mra_axis (
    input  logic               neg,
    input  logic [7:0]         stored,
    input  logic signed [15:0] delta,
    output logic               neg_next,
    output logic [7:0]         stored_next
);

    logic [7:0]         mag;
    logic signed [16:0] mag_ext;
    logic signed [16:0] d_ext;
    logic signed [16:0] sum;
    logic signed [16:0] diff;
    logic [7:0]         sum_neg;
    logic [7:0]         diff_neg;
    logic               d_pos;
    logic [7:0]         mag_next;

    assign mag      = neg ? ~stored : stored;
    assign mag_ext  = signed'({9'd0, mag});
    assign d_ext    = 17'(delta);
    assign sum      = mag_ext + d_ext;        // m + d
    assign diff     = mag_ext - d_ext;        // m - d
    assign sum_neg  = 8'(~sum[7:0]) + 8'd1;   // (-d - m) mod 256
    assign diff_neg = 8'(~diff[7:0]) + 8'd1;  // (d - m) mod 256
    assign d_pos    = !delta[15] && (delta != 16'sd0);

    always_comb
    begin
        neg_next = neg;
        mag_next = sum[7:0];
        if (d_pos)
        begin
            if (neg)
            begin
                if (diff[16])
                begin
                    // crosses zero toward positive
                    mag_next = diff_neg;
                    neg_next = 1'b0;
                end
                else
                begin
                    mag_next = diff[7:0];
                end
            end
            else
            begin
                mag_next = sum[7:0];
            end
        end
        else
        begin
            if (neg)
            begin
                mag_next = diff[7:0];
            end
            else if (!sum[16] && (sum != 17'sd0))
            begin
                mag_next = sum[7:0];
            end
            else
            begin
                // reaches or crosses zero: goes negative (zero move on zero too)
                mag_next = sum_neg;
                neg_next = 1'b1;
            end
        end
    end

    assign stored_next = neg_next ? ~mag_next : mag_next;

endmodule

// File: rtl/mra_report.sv
// Report state registers and the per-transaction update.
module mra_report (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 upd_en,
    input  mra_pkg::req_item_t   item,
    output mra_pkg::rpt_item_t   report_next
);

    logic [7:0] status_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] status_next;
    logic [7:0] x_next;
    logic [7:0] y_next;

    logic       x_neg_next;
    logic       y_neg_next;
    logic [7:0] x_mv;
    logic [7:0] y_mv;
    logic [7:0] btn_mask;

    mra_axis u_axis_x (
        .neg         (status_reg[mra_pkg::X_SIGN_BIT]),
        .stored      (x_reg),
        .delta       (item.dx),
        .neg_next    (x_neg_next),
        .stored_next (x_mv)
    );

    mra_axis u_axis_y (
        .neg         (status_reg[mra_pkg::Y_SIGN_BIT]),
        .stored      (y_reg),
        .delta       (item.dy),
        .neg_next    (y_neg_next),
        .stored_next (y_mv)
    );

    assign btn_mask = {{(8 - mra_pkg::BTN_BITS){1'b0}},
                       mra_pkg::BTN_BITS'(4'b0001 << item.button)};

    always_comb
    begin
        status_next = status_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        case (item.req_type)
            mra_pkg::REQ_PRESS:
            begin
                status_next = status_reg | btn_mask;
            end
            mra_pkg::REQ_RELEASE:
            begin
                status_next = status_reg & ~btn_mask;
            end
            mra_pkg::REQ_MOVE:
            begin
                status_next[mra_pkg::X_SIGN_BIT] = x_neg_next;
                status_next[mra_pkg::Y_SIGN_BIT] = y_neg_next;
                x_next = x_mv;
                y_next = y_mv;
            end
            mra_pkg::REQ_FLUSH:
            begin
                status_next = status_reg & mra_pkg::FLUSH_KEEP_MASK;
                x_next      = 8'd0;
                y_next      = 8'd0;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'd0;
            x_reg      <= 8'd0;
            y_reg      <= 8'd0;
        end
        else if (upd_en)
        begin
            status_reg <= status_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    assign report_next.status_out = status_next;
    assign report_next.x_out      = x_next;
    assign report_next.y_out      = y_next;

endmodule

// File: rtl/mouse_report_accumulator_top.sv
// Top level of the mouse report accumulator: input register, update, result register.
//
// Keeps a three-byte mouse report (status, x, y) and returns the full report
// after every request transaction. Press and release set or clear one of four
// button bits; a move adds signed 16-bit displacements to each axis held in
// sign-magnitude form (sign in status bits 4/5, magnitude stored as its ones'
// complement when negative, wrapping modulo 256); a flush clears movement,
// signs and overflow bits and keeps the buttons. A zero move on a zero,
// positive axis turns it into negative zero (byte 0xFF). The overflow bits are
// held but never set. Throughput is one transaction per cycle while the report
// channel is not stalled. An accepted request is loaded into the input
// register, and from there the report moves through the update logic into the
// result register, where it shows on rpt and can be taken.
// A stalled report holds the input register, which then stalls the request
// channel until the report is taken. The report state is written when a
// transaction leaves the input register, so each transaction sees the state
// left by the one before it.
module mouse_report_accumulator_top (
    input  logic               clk,
    input  logic               rst_n,

    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  mra_pkg::req_item_t req,

    // report channel
    output logic               rpt_valid,
    input  logic               rpt_stall,
    output mra_pkg::rpt_item_t rpt
);

    logic               in_valid_reg;
    mra_pkg::req_item_t in_item_reg;
    logic               rpt_valid_reg;
    mra_pkg::rpt_item_t rpt_reg;
    mra_pkg::rpt_item_t report_next;
    logic               advance;

    // The input stage moves on when the result register is empty or being taken.
    assign advance   = in_valid_reg && (!rpt_valid_reg || !rpt_stall);
    assign req_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            in_item_reg <= req;
        end
    end

    mra_report u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (advance),
        .item        (in_item_reg),
        .report_next (report_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rpt_valid_reg <= 1'b1;
        end
        else if (!rpt_stall)
        begin
            rpt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rpt_reg <= report_next;
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the mouse report accumulator: directed and random transactions.
`timescale 1ns / 1ps

module tb;

    // Cycles with no accepted transaction on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Drain time at the end: a margin after the last report.
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_ITEMS   = 530;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    mra_pkg::req_item_t req       = '0;
    logic               rpt_valid;
    logic               rpt_stall = 1'b0;
    mra_pkg::rpt_item_t rpt;

    // When set, neither side inserts idle cycles or stalls.
    logic      quiet = 1'b0;

    // Predicted report state, mirrors what the block holds.
    logic [7:0] model_status = '0;
    logic [7:0] model_x      = '0;
    logic [7:0] model_y      = '0;

    // Reports predicted for accepted requests, oldest first.
    mra_pkg::rpt_item_t pending_reports[$];

    int         err_count   = 0;
    int         idle_cycles = 0;

    mouse_report_accumulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Report prediction
    // ------------------------------------------------------------------

    // One axis in sign-magnitude form. The stored byte is the ones'
    // complement of the magnitude while the sign is set.
    function automatic void update_axis(inout logic neg, inout logic [7:0] stored,
                                        input int d);
        logic [7:0] mag;
        logic       s;
        int         m;
        mag = neg ? ~stored : stored;
        m   = mag;
        s   = neg;
        if (d > 0)
        begin
            if (s)
            begin
                // Negative axis pushed right: shrink, or cross over to positive.
                if (d - m > 0)
                begin
                    m = d - m;
                    s = 1'b0;
                end
                else
                begin
                    m = m - d;
                end
            end
            else
            begin
                m = m + d;
            end
        end
        else
        begin
            if (s)
            begin
                m = m - d;
            end
            else if (m + d > 0)
            begin
                m = m + d;
            end
            else
            begin
                // Includes a zero move on zero magnitude: becomes negative zero.
                m = -d - m;
                s = 1'b1;
            end
        end
        mag    = m[7:0];
        neg    = s;
        stored = s ? ~mag : mag;
    endfunction

    // Apply one request to the predicted state and return the report.
    function automatic mra_pkg::rpt_item_t predict_report(mra_pkg::req_item_t item);
        mra_pkg::rpt_item_t r;
        logic               nx;
        logic               ny;
        case (item.req_type)
            mra_pkg::REQ_PRESS:   model_status[item.button] = 1'b1;
            mra_pkg::REQ_RELEASE: model_status[item.button] = 1'b0;
            mra_pkg::REQ_MOVE:
            begin
                nx = model_status[mra_pkg::X_SIGN_BIT];
                ny = model_status[mra_pkg::Y_SIGN_BIT];
                update_axis(nx, model_x, int'($signed(item.dx)));
                update_axis(ny, model_y, int'($signed(item.dy)));
                // Overflow bits and buttons are left alone.
                model_status[mra_pkg::X_SIGN_BIT] = nx;
                model_status[mra_pkg::Y_SIGN_BIT] = ny;
            end
            default:
            begin
                model_status = model_status & mra_pkg::FLUSH_KEEP_MASK;
                model_x      = '0;
                model_y      = '0;
            end
        endcase
        r.status_out = model_status;
        r.x_out      = model_x;
        r.y_out      = model_y;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each accepted
    // report, and runs the watchdog. Outputs are sampled at the rising
    // edge before the block's registers update.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        mra_pkg::rpt_item_t want;
        logic               moved;
        moved = 1'b0;
        if (rst_n)
        begin
            // A report can never belong to the request accepted at this
            // same edge, so check first, then predict.
            if (rpt_valid && !rpt_stall)
            begin
                moved = 1'b1;
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected report transaction %h", rpt);
                    err_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (rpt.status_out !== want.status_out)
                    begin
                        $error("status_out: expected %h, actual %h",
                               want.status_out, rpt.status_out);
                        err_count++;
                    end
                    if (rpt.x_out !== want.x_out)
                    begin
                        $error("x_out: expected %h, actual %h", want.x_out, rpt.x_out);
                        err_count++;
                    end
                    if (rpt.y_out !== want.y_out)
                    begin
                        $error("y_out: expected %h, actual %h", want.y_out, rpt.y_out);
                        err_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                pending_reports.push_back(predict_report(req));
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Report side backpressure: stalls on about 28 percent of cycles.
    always @(posedge clk)
    begin
        rpt_stall <= !quiet && ($urandom_range(0, 99) < 28);
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    function automatic mra_pkg::req_item_t make_req(mra_pkg::req_type_t kind,
                                                    logic [1:0] btn, int dx, int dy);
        mra_pkg::req_item_t item;
        item.req_type = kind;
        item.button   = btn;
        item.dx       = dx[15:0];
        item.dy       = dy[15:0];
        return item;
    endfunction

    // Present one request, with random idle cycles ahead of it, and hold it
    // until the block takes it.
    task automatic send_req(mra_pkg::req_item_t item);
        while (!quiet && ($urandom_range(0, 99) < 28))
        begin
            req_valid <= 1'b0;
            req       <= make_req(mra_pkg::req_type_t'($urandom_range(0, 3)),
                                  2'($urandom), int'($urandom), int'($urandom));
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic wait_reports_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Mostly small moves so that axes cross zero often; some full-range and
    // edge values so that every bit of the displacement toggles.
    function automatic int random_delta();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return ($urandom_range(0, 1) != 0) ? 1 : -1;
            2, 3:    return int'($signed(16'($urandom)));
            default: return int'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    function automatic mra_pkg::req_item_t random_req();
        int                 pick;
        mra_pkg::req_type_t kind;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            kind = mra_pkg::REQ_PRESS;
        else if (pick < 35)
            kind = mra_pkg::REQ_RELEASE;
        else if (pick < 88)
            kind = mra_pkg::REQ_MOVE;
        else
            kind = mra_pkg::REQ_FLUSH;
        return make_req(kind, 2'($urandom_range(0, 3)), random_delta(), random_delta());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every button pressed, some released, one pressed twice.
    task automatic test_buttons();
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd0, 0, 0));
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd1, 0, 0));
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd2, 0, 0));
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd3, 0, 0));
        send_req(make_req(mra_pkg::REQ_RELEASE, 2'd1, 0, 0));
        send_req(make_req(mra_pkg::REQ_RELEASE, 2'd3, 0, 0));
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd2, 0, 0));
    endtask

    // Zero move on a zero positive axis gives negative zero; a second zero
    // move keeps it there.
    task automatic test_zero_move();
        send_req(make_req(mra_pkg::REQ_MOVE, 2'd0, 0, 0));
        send_req(make_req(mra_pkg::REQ_MOVE, 2'd0, 0, 0));
    endtask

    // Shrinking toward zero, crossing zero both ways, and a positive move
    // that shrinks a negative axis without crossing.
    task automatic test_sign_crossing();
        send_req(make_req(mra_pkg::REQ_FLUSH, 2'd0, 0, 0));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, 5, -5));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, -3, 3));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, -10, 10));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, 4, -4));
    endtask

    // Magnitude wrap modulo 256 and the extremes of the displacement.
    task automatic test_wrap_extremes();
        send_req(make_req(mra_pkg::REQ_FLUSH, 2'd1, 0, 0));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, 200, -200));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, 100, -100));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, 32767, -32768));
        send_req(make_req(mra_pkg::REQ_MOVE,  2'd0, -32768, 32767));
    endtask

    // Fields that a request does not use must have no effect.
    task automatic test_unused_fields();
        send_req(make_req(mra_pkg::REQ_PRESS,   2'd0, -1, 32767));
        send_req(make_req(mra_pkg::REQ_RELEASE, 2'd2, -32768, 1));
        send_req(make_req(mra_pkg::REQ_FLUSH,   2'd3, 12345, -12345));
    endtask

    // Random mix with a stretch of full throughput and two full drains.
    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 150 && i < 260);
            if (i == 300 || i == 450)
                wait_reports_drained();
            send_req(random_req());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buttons();
        test_zero_move();
        test_sign_crossing();
        test_wrap_extremes();
        test_unused_fields();
        test_random();

        wait_reports_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
